/* design/cma_pkg.sv */
// Shared types and codes for the confusion matrix accumulator.
// No dependencies; compiled first.
package cma_pkg;

   typedef logic [1:0]        req_code_type;
   typedef logic [1:0]        status_type;
   typedef logic signed [4:0] label_type;
   typedef logic [31:0]       count_out_type;

   localparam req_code_type REQ_ACCUM = 2'd0;
   localparam req_code_type REQ_CLEAR = 2'd1;
   localparam req_code_type REQ_READ  = 2'd2;

   localparam status_type STATUS_DONE    = 2'd0;
   localparam status_type STATUS_SKIPPED = 2'd1;
   localparam status_type STATUS_RANGE   = 2'd2;

endpackage

/* design/cma_if.sv */
// Valid/ready channel interfaces for request and response words.
// Depends on cma_pkg for payload types.
interface cma_req_if;
   logic                   valid;
   logic                   ready;
   cma_pkg::req_code_type  req_type;
   cma_pkg::label_type     actual_class;
   cma_pkg::label_type     predicted_class;

   modport source (output valid, output req_type, output actual_class,
                   output predicted_class, input ready);
   modport sink   (input valid, input req_type, input actual_class,
                   input predicted_class, output ready);
endinterface

interface cma_rsp_if;
   logic                   valid;
   logic                   ready;
   cma_pkg::status_type    status;
   cma_pkg::count_out_type cell_count;
   cma_pkg::count_out_type row_total;
   cma_pkg::count_out_type col_total;
   cma_pkg::count_out_type diag_total;
   cma_pkg::count_out_type grand_total;

   modport source (output valid, output status, output cell_count, output row_total,
                   output col_total, output diag_total, output grand_total, input ready);
   modport sink   (input valid, input status, input cell_count, input row_total,
                   input col_total, input diag_total, input grand_total, output ready);
endinterface

/* design/confusion_matrix_accumulator.sv */
// Confusion matrix accumulator: actual-by-predicted count matrix with running totals.
// Depends on cma_pkg and the cma_req_if / cma_rsp_if interfaces.
//
// Usage:
//   req_bus carries one request word: accumulate a label pair, clear all counts,
//   or read one cell. rsp_bus returns exactly one response word per request with
//   the cell count, its row and column totals, the diagonal and the grand total.
//   For accumulate and read, the accepting cycle issues the reads of the cell,
//   row and column memories; the update state then updates, writes back and
//   loads the response register. A new request is not taken until that
//   read-modify-write through the synchronous memories is done.
//   A clear walks every entry of the cell memory one entry a cycle, clearing row
//   and column totals alongside, and then loads its response once the response
//   register is free.
//   After reset the same clearing pass runs before req_bus.ready first rises;
//   no response is produced for it.
//   The response register holds while rsp_bus.ready is low; the next request is
//   still accepted, and its update waits until the response register frees up.
//   Every counter saturates at its maximum; wide counters show their low 32 bits.
module confusion_matrix_accumulator #(
   parameter int NUM_ACTUAL    = 16,
   parameter int NUM_PREDICTED = 16,
   parameter int COUNT_WIDTH   = 32
) (
   input logic        clock,
   input logic        reset,
   cma_req_if.sink    req_bus,
   cma_rsp_if.source  rsp_bus
);

   localparam int CELL_DEPTH = NUM_ACTUAL * NUM_PREDICTED;
   localparam int CELL_AW    = $clog2(CELL_DEPTH);
   localparam int ROW_AW     = $clog2(NUM_ACTUAL);
   localparam int COL_AW     = $clog2(NUM_PREDICTED);

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SWEEP,
      ST_CLR_RSP
   } state_type;

   function automatic count_type sat_inc(input count_type c);
      return (&c) ? c : c + COUNT_WIDTH'(1);
   endfunction

   // Memories
   count_type cell_mem [CELL_DEPTH];
   count_type row_mem  [NUM_ACTUAL];
   count_type col_mem  [NUM_PREDICTED];

   count_type cell_rd_ff, row_rd_ff, col_rd_ff;

   // Control and registered outputs
   state_type           state_ff;
   logic                clr_pend_ff;
   logic [CELL_AW-1:0]  sweep_ff;
   count_type           diag_ff, all_ff;
   logic                rsp_valid_ff;
   cma_pkg::status_type rsp_status_ff;
   cma_pkg::count_out_type rsp_cell_ff, rsp_row_ff, rsp_col_ff, rsp_diag_ff, rsp_all_ff;

   // Latched request
   cma_pkg::status_type status_ff;
   logic                accum_ff;
   logic                diag_hit_ff;
   logic [CELL_AW-1:0]  cell_addr_ff;
   logic [ROW_AW-1:0]   row_addr_ff;
   logic [COL_AW-1:0]   col_addr_ff;

   // Request decode
   logic                accept;
   logic                is_clear;
   logic                a_in_range, p_in_range;
   cma_pkg::status_type status_in;
   logic [CELL_AW-1:0]  cell_addr_in;
   logic [ROW_AW-1:0]   row_addr_in;
   logic [COL_AW-1:0]   col_addr_in;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign is_clear      = (req_bus.req_type == cma_pkg::REQ_CLEAR);

   assign a_in_range = 32'(req_bus.actual_class[3:0]) < 32'(NUM_ACTUAL);
   assign p_in_range = 32'(req_bus.predicted_class[3:0]) < 32'(NUM_PREDICTED);

   always_comb begin
      priority if (req_bus.actual_class[4] || req_bus.predicted_class[4]) begin
         status_in = cma_pkg::STATUS_SKIPPED;
      end else if (!a_in_range || !p_in_range) begin
         status_in = cma_pkg::STATUS_RANGE;
      end else begin
         status_in = cma_pkg::STATUS_DONE;
      end
   end

   assign row_addr_in  = ROW_AW'(req_bus.actual_class[3:0]);
   assign col_addr_in  = COL_AW'(req_bus.predicted_class[3:0]);
   assign cell_addr_in = CELL_AW'(32'(req_bus.actual_class[3:0]) * 32'(NUM_PREDICTED)
                                  + 32'(req_bus.predicted_class[3:0]));

   // Update stage
   logic      out_free;
   logic      counted;
   logic      upd_fire;
   logic      rsp_load;
   count_type cell_new, row_new, col_new, diag_new, all_new;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign upd_fire = (state_ff == ST_UPDATE) && out_free;
   assign rsp_load = upd_fire || ((state_ff == ST_CLR_RSP) && out_free);
   assign counted  = accum_ff && (status_ff == cma_pkg::STATUS_DONE);

   assign cell_new = counted ? sat_inc(cell_rd_ff) : cell_rd_ff;
   assign row_new  = counted ? sat_inc(row_rd_ff) : row_rd_ff;
   assign col_new  = counted ? sat_inc(col_rd_ff) : col_rd_ff;
   assign all_new  = counted ? sat_inc(all_ff) : all_ff;
   assign diag_new = (counted && diag_hit_ff) ? sat_inc(diag_ff) : diag_ff;

   // Memory write ports: sweep clears, update writes back
   logic               sweeping;
   logic               cell_we, row_we, col_we;
   logic [CELL_AW-1:0] cell_waddr;
   logic [ROW_AW-1:0]  row_waddr;
   logic [COL_AW-1:0]  col_waddr;
   count_type          cell_wdata, row_wdata, col_wdata;

   assign sweeping = (state_ff == ST_SWEEP);

   always_comb begin
      if (sweeping) begin
         cell_we    = 1'b1;
         row_we     = 32'(sweep_ff) < 32'(NUM_ACTUAL);
         col_we     = 32'(sweep_ff) < 32'(NUM_PREDICTED);
         cell_waddr = sweep_ff;
         row_waddr  = ROW_AW'(sweep_ff);
         col_waddr  = COL_AW'(sweep_ff);
         cell_wdata = '0;
         row_wdata  = '0;
         col_wdata  = '0;
      end else begin
         cell_we    = upd_fire && counted;
         row_we     = upd_fire && counted;
         col_we     = upd_fire && counted;
         cell_waddr = cell_addr_ff;
         row_waddr  = row_addr_ff;
         col_waddr  = col_addr_ff;
         cell_wdata = cell_new;
         row_wdata  = row_new;
         col_wdata  = col_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_waddr] <= cell_wdata;
      end
      if (accept) begin
         cell_rd_ff <= cell_mem[cell_addr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_waddr] <= row_wdata;
      end
      if (accept) begin
         row_rd_ff <= row_mem[row_addr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[col_waddr] <= col_wdata;
      end
      if (accept) begin
         col_rd_ff <= col_mem[col_addr_in];
      end
   end

   // Hold request fields for the update cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         accum_ff     <= (req_bus.req_type == cma_pkg::REQ_ACCUM);
         diag_hit_ff  <= (req_bus.actual_class == req_bus.predicted_class);
         cell_addr_ff <= cell_addr_in;
         row_addr_ff  <= row_addr_in;
         col_addr_ff  <= col_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         clr_pend_ff  <= 1'b0;
         sweep_ff     <= '0;
         diag_ff      <= '0;
         all_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (is_clear) begin
                     state_ff    <= ST_SWEEP;
                     clr_pend_ff <= 1'b1;
                     sweep_ff    <= '0;
                     diag_ff     <= '0;
                     all_ff      <= '0;
                  end else begin
                     state_ff <= ST_UPDATE;
                  end
               end
            end
            ST_UPDATE: begin
               // wait here until the response register is free
               if (out_free) begin
                  diag_ff       <= diag_new;
                  all_ff        <= all_new;
                  rsp_status_ff <= status_ff;
                  if (status_ff == cma_pkg::STATUS_DONE) begin
                     rsp_cell_ff <= 32'(cell_new);
                     rsp_row_ff  <= 32'(row_new);
                     rsp_col_ff  <= 32'(col_new);
                  end else begin
                     rsp_cell_ff <= '0;
                     rsp_row_ff  <= '0;
                     rsp_col_ff  <= '0;
                  end
                  rsp_diag_ff <= 32'(diag_new);
                  rsp_all_ff  <= 32'(all_new);
                  state_ff    <= ST_IDLE;
               end
            end
            ST_SWEEP: begin
               if (sweep_ff == CELL_AW'(CELL_DEPTH - 1)) begin
                  state_ff <= clr_pend_ff ? ST_CLR_RSP : ST_IDLE;
               end else begin
                  sweep_ff <= sweep_ff + CELL_AW'(1);
               end
            end
            ST_CLR_RSP: begin
               if (out_free) begin
                  rsp_status_ff <= cma_pkg::STATUS_DONE;
                  rsp_cell_ff   <= '0;
                  rsp_row_ff    <= '0;
                  rsp_col_ff    <= '0;
                  rsp_diag_ff   <= '0;
                  rsp_all_ff    <= '0;
                  clr_pend_ff   <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.cell_count  = rsp_cell_ff;
   assign rsp_bus.row_total   = rsp_row_ff;
   assign rsp_bus.col_total   = rsp_col_ff;
   assign rsp_bus.diag_total  = rsp_diag_ff;
   assign rsp_bus.grand_total = rsp_all_ff;

`ifndef NO_ASSERTIONS
   // every diagonal hit is also counted in the grand total
   a_diag_le_all: assert property (@(posedge clock) disable iff (reset)
      diag_ff <= all_ff)
      else $error("diagonal total exceeds grand total");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (accept && is_clear) |=> (diag_ff == '0 && all_ff == '0 && state_ff == ST_SWEEP))
      else $error("clear did not zero the totals");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_UPDATE || $past(state_ff) == ST_CLR_RSP))
      else $error("response raised outside update or clear completion");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !cell_we)
      else $error("cell memory written while idle");
`endif

endmodule
